// ===== rtl/core/aob_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aob_pkg: shared types and constants of the RGBA8 over-blend core
// Channel, weight and divider widths, the stage load vector type and one
// restoring division step used by the quotient pipeline.
// ----------------------------------------------------------------------------
package aob_pkg;

    localparam int unsigned CH_W       = 8;     // color / alpha channel width
    localparam int unsigned NUM_CH     = 3;     // red, green, blue
    localparam int unsigned WGT_W      = 16;    // weight width, up to 255*255
    localparam int unsigned NUM_W      = 24;    // numerator width, up to 255*65025
    localparam int unsigned DIV_STAGES = 4;     // register stages of the divider
    localparam int unsigned DIV_BPS    = 2;     // quotient bits per divider stage

    localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

    typedef logic [CH_W-1:0]               t_chan;
    typedef logic [NUM_CH-1:0][CH_W-1:0]   t_rgb;
    typedef logic [NUM_CH-1:0][NUM_W-1:0]  t_rgb_num;
    typedef logic [WGT_W-1:0]              t_wgt;
    typedef logic [DIV_STAGES-1:0]         t_div_ld;

    // One restoring step: compare against the shifted divisor and subtract.
    // Result is {quotient bit, new remainder}.
    function automatic logic [NUM_W:0] div_bit(
        input logic [NUM_W-1:0] rem,
        input logic [WGT_W-1:0] den,
        input int unsigned      sh
    );
        logic [NUM_W-1:0] d;
        d = NUM_W'(den) << sh;
        if (rem >= d) begin
            return {1'b1, rem - d};
        end
        return {1'b0, rem};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aob_weight.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aob_weight: first pipeline stage, blend weights
// Registers the destination and source weights and the channel pair. In flag
// mode the weights pick one side with unit weight so the divider passes it.
// ----------------------------------------------------------------------------
module aob_weight (
    input  wire logic          i_clk,
    input  wire logic          i_ld,
    input  wire aob_pkg::t_rgb i_dst,
    input  wire aob_pkg::t_chan i_dst_alpha,
    input  wire logic          i_dst_true,
    input  wire aob_pkg::t_rgb i_src,
    input  wire aob_pkg::t_chan i_src_alpha,
    input  wire logic          i_src_true,
    output aob_pkg::t_wgt      o_wd,
    output aob_pkg::t_wgt      o_ws,
    output aob_pkg::t_rgb      o_cd,
    output aob_pkg::t_rgb      o_cs,
    output logic               o_tc,
    output logic               o_sa_nz
);

    aob_pkg::t_wgt n_wd;
    aob_pkg::t_wgt n_ws;
    logic          n_tc;
    logic          n_sa_nz;
    aob_pkg::t_wgt r_wd;
    aob_pkg::t_wgt r_ws;
    aob_pkg::t_rgb r_cd;
    aob_pkg::t_rgb r_cs;
    logic          r_tc;
    logic          r_sa_nz;

    // Pick the weights: true-color over blend, or unit weight on one side
    always_comb begin
        n_tc    = i_dst_true & i_src_true;
        n_sa_nz = (i_src_alpha != '0);
        if (n_tc) begin
            n_wd = aob_pkg::WGT_W'(i_dst_alpha) * aob_pkg::WGT_W'(aob_pkg::FULL_SCALE);
            n_ws = aob_pkg::WGT_W'(i_src_alpha)
                 * aob_pkg::WGT_W'(aob_pkg::FULL_SCALE - i_dst_alpha);
        end else begin
            n_wd = aob_pkg::WGT_W'(!n_sa_nz);
            n_ws = aob_pkg::WGT_W'(n_sa_nz);
        end
    end

    // Advance the stage
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_wd    <= n_wd;
            r_ws    <= n_ws;
            r_cd    <= i_dst;
            r_cs    <= i_src;
            r_tc    <= n_tc;
            r_sa_nz <= n_sa_nz;
        end
    end

    assign o_wd    = r_wd;
    assign o_ws    = r_ws;
    assign o_cd    = r_cd;
    assign o_cs    = r_cs;
    assign o_tc    = r_tc;
    assign o_sa_nz = r_sa_nz;

endmodule

`default_nettype wire

// ===== rtl/core/aob_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aob_mix: second pipeline stage, weighted sums and alpha
// Forms the three weighted channel sums, the divisor (forced nonzero, since a
// zero divisor only comes with a zero numerator) and the result alpha.
// ----------------------------------------------------------------------------
module aob_mix (
    input  wire logic            i_clk,
    input  wire logic            i_ld,
    input  wire aob_pkg::t_wgt   i_wd,
    input  wire aob_pkg::t_wgt   i_ws,
    input  wire aob_pkg::t_rgb   i_cd,
    input  wire aob_pkg::t_rgb   i_cs,
    input  wire logic            i_tc,
    input  wire logic            i_sa_nz,
    output aob_pkg::t_rgb_num    o_num,
    output aob_pkg::t_wgt        o_den,
    output aob_pkg::t_chan       o_alpha
);

    aob_pkg::t_rgb_num        n_num;
    aob_pkg::t_wgt            n_w;
    aob_pkg::t_wgt            n_den;
    logic [aob_pkg::WGT_W:0]  n_div255;
    aob_pkg::t_chan           n_alpha;
    aob_pkg::t_rgb_num        r_num;
    aob_pkg::t_wgt            r_den;
    aob_pkg::t_chan           r_alpha;

    // Weighted sum per channel
    always_comb begin
        for (int c = 0; c < aob_pkg::NUM_CH; c++) begin
            n_num[c] = aob_pkg::NUM_W'(i_cd[c]) * aob_pkg::NUM_W'(i_wd)
                     + aob_pkg::NUM_W'(i_cs[c]) * aob_pkg::NUM_W'(i_ws);
        end
    end

    // Divisor and alpha; w/255 as (w + 1 + (w >> 8)) >> 8, exact below 65535
    always_comb begin
        n_w      = i_wd + i_ws;
        n_den    = (n_w == '0) ? aob_pkg::WGT_W'(1) : n_w;
        n_div255 = (aob_pkg::WGT_W + 1)'(n_w) + (aob_pkg::WGT_W + 1)'(1)
                 + (aob_pkg::WGT_W + 1)'(n_w >> aob_pkg::CH_W);
        if (i_tc) begin
            n_alpha = n_div255[aob_pkg::CH_W +: aob_pkg::CH_W];
        end else begin
            n_alpha = aob_pkg::CH_W'(i_sa_nz);
        end
    end

    // Advance the stage
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_num   <= n_num;
            r_den   <= n_den;
            r_alpha <= n_alpha;
        end
    end

    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_alpha = r_alpha;

endmodule

`default_nettype wire

// ===== rtl/core/aob_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aob_div: pipelined restoring divider, three channels
// Each register stage resolves two quotient bits for every channel against a
// shared divisor. The quotient is known to fit in eight bits.
// ----------------------------------------------------------------------------
module aob_div (
    input  wire logic              i_clk,
    input  wire aob_pkg::t_div_ld  i_ld,
    input  wire aob_pkg::t_rgb_num i_num,
    input  wire aob_pkg::t_wgt     i_den,
    output aob_pkg::t_rgb          o_quo
);

    localparam int unsigned NS = aob_pkg::DIV_STAGES;

    aob_pkg::t_rgb_num r_rem [NS];
    aob_pkg::t_rgb     r_quo [NS];
    aob_pkg::t_wgt     r_den [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int unsigned K_HI = aob_pkg::CH_W - 1 - s * aob_pkg::DIV_BPS;
        localparam int unsigned K_LO = K_HI - 1;

        aob_pkg::t_rgb_num     rem_in;
        aob_pkg::t_rgb         quo_in;
        aob_pkg::t_wgt         den_in;
        aob_pkg::t_rgb_num     n_rem;
        aob_pkg::t_rgb         n_quo;
        logic [aob_pkg::NUM_W:0] step_hi;
        logic [aob_pkg::NUM_W:0] step_lo;

        // Select the stage input
        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
            assign den_in = r_den[s-1];
        end

        // Resolve two quotient bits per channel
        always_comb begin
            n_rem   = rem_in;
            n_quo   = quo_in;
            step_hi = '0;
            step_lo = '0;
            for (int c = 0; c < aob_pkg::NUM_CH; c++) begin
                step_hi         = aob_pkg::div_bit(rem_in[c], den_in, K_HI);
                step_lo         = aob_pkg::div_bit(step_hi[aob_pkg::NUM_W-1:0],
                                                   den_in, K_LO);
                n_quo[c][K_HI]  = step_hi[aob_pkg::NUM_W];
                n_quo[c][K_LO]  = step_lo[aob_pkg::NUM_W];
                n_rem[c]        = step_lo[aob_pkg::NUM_W-1:0];
            end
        end

        // Advance the stage
        always_ff @(posedge i_clk) begin
            if (i_ld[s]) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
                r_den[s] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[NS-1];

endmodule

`default_nettype wire

// ===== rtl/core/alpha_over_blend_rgba8_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one pixel per clock while i_stall is low; the six pipeline
// register stages (weights, weighted sums, four two-bit divider stages) each
// hold one request.
// A stall on the output fills bubbles first, then backs up stage by stage.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// alpha_over_blend_rgba8_core: RGBA8 over compositing, destination on top
// Exact integer over blend when both pixels are true color, flag-mode source
// replace otherwise. Valid/stall on both sides, valid bits ride with the data.
// ----------------------------------------------------------------------------
module alpha_over_blend_rgba8_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire logic [7:0] i_dst_red,
    input  wire logic [7:0] i_dst_green,
    input  wire logic [7:0] i_dst_blue,
    input  wire logic [7:0] i_dst_alpha,
    input  wire logic       i_dst_true,
    input  wire logic [7:0] i_src_red,
    input  wire logic [7:0] i_src_green,
    input  wire logic [7:0] i_src_blue,
    input  wire logic [7:0] i_src_alpha,
    input  wire logic       i_src_true,
    output logic       o_valid,
    input  wire logic  i_stall,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha
);

    localparam int unsigned NSTG = 2 + aob_pkg::DIV_STAGES;

    logic [NSTG-1:0]   r_vld;
    logic [NSTG-1:0]   ld;
    aob_pkg::t_chan    r_alpha [2:NSTG-1];

    aob_pkg::t_rgb     w_dst;
    aob_pkg::t_rgb     w_src;
    aob_pkg::t_wgt     w_wd;
    aob_pkg::t_wgt     w_ws;
    aob_pkg::t_rgb     w_cd;
    aob_pkg::t_rgb     w_cs;
    logic              w_tc;
    logic              w_sa_nz;
    aob_pkg::t_rgb_num w_num;
    aob_pkg::t_wgt     w_den;
    aob_pkg::t_chan    w_alpha;
    aob_pkg::t_rgb     w_quo;

    // Stage loads: a stage takes new data when empty or when it moves on
    always_comb begin
        ld[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign o_stall = !ld[0];
    assign o_valid = r_vld[NSTG-1];

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign w_dst = {i_dst_blue, i_dst_green, i_dst_red};
    assign w_src = {i_src_blue, i_src_green, i_src_red};

    aob_weight u_weight (
        .i_clk       (i_clk),
        .i_ld        (ld[0]),
        .i_dst       (w_dst),
        .i_dst_alpha (i_dst_alpha),
        .i_dst_true  (i_dst_true),
        .i_src       (w_src),
        .i_src_alpha (i_src_alpha),
        .i_src_true  (i_src_true),
        .o_wd        (w_wd),
        .o_ws        (w_ws),
        .o_cd        (w_cd),
        .o_cs        (w_cs),
        .o_tc        (w_tc),
        .o_sa_nz     (w_sa_nz)
    );

    aob_mix u_mix (
        .i_clk   (i_clk),
        .i_ld    (ld[1]),
        .i_wd    (w_wd),
        .i_ws    (w_ws),
        .i_cd    (w_cd),
        .i_cs    (w_cs),
        .i_tc    (w_tc),
        .i_sa_nz (w_sa_nz),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_alpha (w_alpha)
    );

    aob_div u_div (
        .i_clk (i_clk),
        .i_ld  (ld[NSTG-1:2]),
        .i_num (w_num),
        .i_den (w_den),
        .o_quo (w_quo)
    );

    // Carry alpha alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_alpha[2] <= w_alpha;
        end
        for (int k = 3; k < NSTG; k++) begin
            if (ld[k]) begin
                r_alpha[k] <= r_alpha[k-1];
            end
        end
    end

    assign o_out_red   = w_quo[0];
    assign o_out_green = w_quo[1];
    assign o_out_blue  = w_quo[2];
    assign o_out_alpha = r_alpha[NSTG-1];

    // Backpressure reaches the input only when every stage holds a request
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled while a pipeline stage is empty");

    // A request leaving the weight stage lands in the sum stage
    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && ld[1]) |=> r_vld[1])
        else $error("request lost between weight and sum stages");

    // The divider never sees a zero divisor
    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (w_den != '0))
        else $error("zero divisor entered the divider");

    // A result held under stall stays in the last stage, unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(w_quo) && $stable(o_out_alpha)))
        else $error("stalled result dropped or changed in the output stage");

endmodule

`default_nettype wire
